// ===== hw/rtl/ipv4_fragment_header_generator_macros.svh =====
// Assertion macros used by the fragment header generator RTL.
`ifndef IPV4_FRAGMENT_HEADER_GENERATOR_MACROS_SVH
`define IPV4_FRAGMENT_HEADER_GENERATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define IPHG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define IPHG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/iphg_pkg.sv =====
// Types and constants for the IPv4 fragment header generator.
package iphg_pkg;

    localparam int APB_ADDR_W = 4;
    localparam int REG_IDX_W  = 2;

    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam reg_idx_t REG_LOCAL_ADDRESS     = 2'd0;
    localparam reg_idx_t REG_TIME_TO_LIVE      = 2'd1;
    localparam reg_idx_t REG_MAX_PAYLOAD_UNITS = 2'd2;

    localparam logic [31:0] LOCAL_ADDRESS_RST     = 32'd0;
    localparam logic [7:0]  TIME_TO_LIVE_RST      = 8'd64;
    localparam logic [7:0]  MAX_PAYLOAD_UNITS_RST = 8'd185;

    localparam logic [7:0]  UNIT_MIN     = 8'd128;
    localparam logic [7:0]  UNIT_MAX     = 8'd185;
    localparam logic [10:0] HDR_BYTES    = 11'd20;
    localparam logic [15:0] VER_IHL_TOS  = 16'h4500;

    typedef struct packed {
        logic [31:0] local_address;
        logic [7:0]  time_to_live;
        logic [7:0]  max_payload_units;
    } cfg_t;

    // One request to the shared ones' complement adder
    typedef struct packed {
        logic        en;
        logic [15:0] a;
        logic [15:0] b;
    } csum_req_t;

endpackage

// ===== hw/rtl/iphg_if.sv =====
// Request and header channel interfaces of the fragment header generator.
interface iphg_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] payload_length;
    logic [31:0] dest_address;
    logic [7:0]  proto_number;

    modport source (output valid, payload_length, dest_address, proto_number, input ready);
    modport sink   (input valid, payload_length, dest_address, proto_number, output ready);
endinterface

interface iphg_hdr_if;
    logic        valid;
    logic        ready;
    logic [15:0] identification;
    logic [12:0] fragment_offset;
    logic        more_fragments;
    logic [10:0] total_length;
    logic [15:0] header_checksum;
    logic        last_fragment;

    modport source (output valid, identification, fragment_offset, more_fragments,
                    total_length, header_checksum, last_fragment, input ready);
    modport sink   (input valid, identification, fragment_offset, more_fragments,
                    total_length, header_checksum, last_fragment, output ready);
endinterface

// ===== hw/rtl/ipv4_fragment_header_generator.sv =====
// Top level: request sequencer, output register and configuration port.
//
// req channel (sink): one packet request per handshake: payload_length,
// dest_address, proto_number. hdr channel (source): one IPv4 header
// description per fragment, last_fragment set on the final one.
// Configuration: APB writes to local_address (0x0), time_to_live (0x4),
// max_payload_units (0x8); pready is always high, reads return the value.
// Sequence: after a request is taken the checksum base (seven header
// words) is summed through one shared ones' complement adder, then each
// fragment steps through its length word, flags word and output load
// and then waits in the output register until hdr takes it.
// ready is high only while the block is idle. A stalled hdr holds the
// current header in the output register; the next fragment starts after
// it is taken. Reset clears the packet counter to zero and loads the
// register defaults (0, 64, 185).
`include "ipv4_fragment_header_generator_macros.svh"

module ipv4_fragment_header_generator import iphg_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    iphg_req_if.sink              req,
    iphg_hdr_if.source            hdr
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_BASE = 3'd1;
    localparam logic [2:0] S_TOT  = 3'd2;
    localparam logic [2:0] S_FLG  = 3'd3;
    localparam logic [2:0] S_LOAD = 3'd4;
    localparam logic [2:0] S_WAIT = 3'd5;

    localparam logic [2:0] BASE_LAST = 3'd6;

    cfg_t        cfg;
    csum_req_t   csum_req;
    logic [15:0] acc;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  step_reg, step_next;
    logic        first_reg, first_next;
    logic [15:0] pkt_cnt_reg, pkt_cnt_next;
    logic        out_valid_reg, out_valid_next;

    logic [15:0] len_reg;
    logic [12:0] off_reg;
    logic [7:0]  units_reg;
    logic [31:0] dst_reg;
    logic [7:0]  proto_reg;
    logic [15:0] id_reg;
    logic [15:0] base_reg;

    logic [15:0] out_id_reg;
    logic [12:0] out_off_reg;
    logic        out_mf_reg;
    logic [10:0] out_tot_reg;
    logic [15:0] out_csum_reg;

    logic        req_acc;
    logic [7:0]  units_clamped;
    logic [10:0] chunk;
    logic        full;
    logic [10:0] frag_bytes;
    logic [10:0] tot;
    logic [15:0] flg_word;
    logic [15:0] base_word;

    iphg_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    iphg_csum u_csum (
        .clk (clk),
        .req (csum_req),
        .sum (acc)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign req_acc   = req.valid && req.ready;

    assign units_clamped = (cfg.max_payload_units < UNIT_MIN) ? UNIT_MIN :
                           (cfg.max_payload_units > UNIT_MAX) ? UNIT_MAX :
                           cfg.max_payload_units;

    assign chunk      = {units_reg, 3'b000};
    assign full       = len_reg > {5'd0, chunk};
    assign frag_bytes = full ? chunk : len_reg[10:0];
    assign tot        = HDR_BYTES + frag_bytes;
    assign flg_word   = {2'b00, full, off_reg};

    always_comb
    begin
        case (step_reg)
            3'd0:    base_word = VER_IHL_TOS;
            3'd1:    base_word = {cfg.time_to_live, proto_reg};
            3'd2:    base_word = cfg.local_address[31:16];
            3'd3:    base_word = cfg.local_address[15:0];
            3'd4:    base_word = dst_reg[31:16];
            3'd5:    base_word = dst_reg[15:0];
            default: base_word = id_reg;
        endcase
    end

    always_comb
    begin
        csum_req.en = 1'b0;
        csum_req.a  = acc;
        csum_req.b  = 16'd0;
        case (state_reg)
            S_BASE:
            begin
                csum_req.en = 1'b1;
                csum_req.a  = (step_reg == 3'd0) ? 16'd0 : acc;
                csum_req.b  = base_word;
            end
            S_TOT:
            begin
                // first fragment: acc still holds the base sum
                csum_req.en = 1'b1;
                csum_req.a  = first_reg ? acc : base_reg;
                csum_req.b  = {5'd0, tot};
            end
            S_FLG:
            begin
                csum_req.en = 1'b1;
                csum_req.b  = flg_word;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        first_next     = first_reg;
        pkt_cnt_next   = pkt_cnt_reg;
        out_valid_next = out_valid_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_acc)
                begin
                    state_next   = S_BASE;
                    step_next    = 3'd0;
                    first_next   = 1'b1;
                    pkt_cnt_next = pkt_cnt_reg + 16'd1;
                end
            end
            S_BASE:
            begin
                step_next = step_reg + 3'd1;
                if (step_reg == BASE_LAST)
                begin
                    state_next = S_TOT;
                end
            end
            S_TOT:
            begin
                first_next = 1'b0;
                state_next = S_FLG;
            end
            S_FLG:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                out_valid_next = 1'b1;
                state_next     = S_WAIT;
            end
            S_WAIT:
            begin
                if (hdr.ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = out_mf_reg ? S_TOT : S_IDLE;
                end
            end
            default:
            begin
                state_next     = S_IDLE;
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= 3'd0;
            first_reg     <= 1'b0;
            pkt_cnt_reg   <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            first_reg     <= first_next;
            pkt_cnt_reg   <= pkt_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_acc)
        begin
            len_reg   <= req.payload_length;
            dst_reg   <= req.dest_address;
            proto_reg <= req.proto_number;
            id_reg    <= pkt_cnt_reg;
            units_reg <= units_clamped;
            off_reg   <= 13'd0;
        end
        if (state_reg == S_TOT && first_reg)
        begin
            base_reg <= acc;
        end
        if (state_reg == S_LOAD)
        begin
            out_id_reg   <= id_reg;
            out_off_reg  <= off_reg;
            out_mf_reg   <= full;
            out_tot_reg  <= tot;
            out_csum_reg <= ~acc;
            if (full)
            begin
                len_reg <= len_reg - {5'd0, chunk};
                off_reg <= off_reg + {5'd0, units_reg};
            end
        end
    end

    assign hdr.valid           = out_valid_reg;
    assign hdr.identification  = out_id_reg;
    assign hdr.fragment_offset = out_off_reg;
    assign hdr.more_fragments  = out_mf_reg;
    assign hdr.total_length    = out_tot_reg;
    assign hdr.header_checksum = out_csum_reg;
    assign hdr.last_fragment   = ~out_mf_reg;

    `IPHG_ASSERT_NOW(a_busy_while_out, hdr.valid, !req.ready, "request taken while header pending")
    `IPHG_ASSERT_NEXT(a_id_advance, req.valid && req.ready, pkt_cnt_reg == $past(pkt_cnt_reg) + 16'd1, "packet id did not advance")
    `IPHG_ASSERT_NOW(a_full_len, hdr.valid && hdr.more_fragments, hdr.total_length == chunk + HDR_BYTES, "non-final fragment not full size")
    `IPHG_ASSERT_NOW(a_out_in_wait, hdr.valid, state_reg == S_WAIT, "header shown outside wait state")

endmodule

// ===== hw/rtl/iphg_cfg.sv =====
// APB configuration registers of the fragment header generator.
module iphg_cfg import iphg_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.local_address     <= LOCAL_ADDRESS_RST;
            cfg_reg.time_to_live      <= TIME_TO_LIVE_RST;
            cfg_reg.max_payload_units <= MAX_PAYLOAD_UNITS_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_LOCAL_ADDRESS:     cfg_reg.local_address     <= pwdata;
                REG_TIME_TO_LIVE:      cfg_reg.time_to_live      <= pwdata[7:0];
                REG_MAX_PAYLOAD_UNITS: cfg_reg.max_payload_units <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_LOCAL_ADDRESS:     prdata = cfg_reg.local_address;
            REG_TIME_TO_LIVE:      prdata = {24'd0, cfg_reg.time_to_live};
            REG_MAX_PAYLOAD_UNITS: prdata = {24'd0, cfg_reg.max_payload_units};
            default:               prdata = 32'd0;
        endcase
    end

endmodule

// ===== hw/rtl/iphg_csum.sv =====
// Shared 16-bit ones' complement adder with result register.
module iphg_csum import iphg_pkg::*; (
    input  logic        clk,
    input  csum_req_t   req,
    output logic [15:0] sum
);

    logic [15:0] sum_reg;
    logic [16:0] raw;
    logic [15:0] folded;

    // end-around carry; low half plus carry cannot overflow again
    assign raw    = {1'b0, req.a} + {1'b0, req.b};
    assign folded = raw[15:0] + {15'd0, raw[16]};
    assign sum    = sum_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            sum_reg <= folded;
        end
    end

endmodule
